// ===== design/bssc_pkg.sv =====
// ----------------------------------------------------------------------------
// bssc_pkg: shared types and constants of the BLDC six-step speed controller
// Holds the configuration register set and its reset values, the register
// index codes, the sector and switch codes, and the carrier constants.
// ----------------------------------------------------------------------------
package bssc_pkg;

  // Default width of the internal phase current command
  localparam int unsigned DataWidthDef = 16;

  // Configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SPEED_CMD     = 3'd0,
    CFG_SPEED_KP      = 3'd1,
    CFG_SPEED_KI      = 3'd2,
    CFG_TORQUE_LIM    = 3'd3,
    CFG_TORQUE_TO_CUR = 3'd4,
    CFG_CUR_GAIN      = 3'd5,
    CFG_VOLT_LIM      = 3'd6,
    CFG_CARRIER_STEP  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] speed_command;      // signed Q12.4
    logic [15:0] speed_prop_gain;    // unsigned Q4.12
    logic [23:0] speed_int_gain;     // unsigned Q0.32
    logic [14:0] torque_limit;       // Q7.8
    logic [15:0] torque_to_current;  // Q8.8
    logic [9:0]  current_gain;       // integer V/A
    logic [14:0] voltage_limit;      // Q7.8
    logic [13:0] carrier_step;       // Q6.8
  } cfg_t;

  localparam cfg_t CfgRst = '{
    speed_command:     16'd0,
    speed_prop_gain:   16'd410,
    speed_int_gain:    24'd43,
    torque_limit:      15'd768,
    torque_to_current: 16'd1222,
    current_gain:      10'd100,
    voltage_limit:     15'd2304,
    carrier_step:      14'd614
  };

  // Commutation sector, sector 0 spans 330 to 30 degrees
  typedef enum logic [2:0] {
    SEC0 = 3'd0,
    SEC1 = 3'd1,
    SEC2 = 3'd2,
    SEC3 = 3'd3,
    SEC4 = 3'd4,
    SEC5 = 3'd5
  } sector_e;

  // Phase leg drive
  typedef enum logic [1:0] {
    SW_LOW   = 2'd0,
    SW_HIGH  = 2'd1,
    SW_FLOAT = 2'd2
  } switch_e;

  // Pipeline step: adv moves all stages, vld marks a real request moving in
  typedef struct packed {
    logic adv;
    logic vld;
  } stage_ctl_t;

  // Triangle carrier, Q8.8 on a period of 40.0 with peak 10.0
  localparam int unsigned CarrierW      = 40;
  localparam int unsigned TriW          = 17;
  localparam int unsigned CarrierPeak   = 2560;
  localparam int unsigned CarrierPeriod = 10240;

  // Rotor angle in tenths of a degree
  localparam int unsigned AngleFull = 3600;
  localparam int unsigned SecBound0 = 300;
  localparam int unsigned SecBound1 = 900;
  localparam int unsigned SecBound2 = 1500;
  localparam int unsigned SecBound3 = 2100;
  localparam int unsigned SecBound4 = 2700;
  localparam int unsigned SecBound5 = 3300;

endpackage

// ===== design/bldc_six_step_speed_controller_unit.sv =====
// ----------------------------------------------------------------------------
// bldc_six_step_speed_controller_unit: BLDC six-step speed controller
// One control tick per request: PI speed loop, torque to current scaling,
// sector commutation and per-phase current loops against a triangle carrier.
//
//   channel   dir  handshake                 payload
//   s_axis    in   s_axis_tvalid/tready      speed, angle, phase currents
//   m_axis    out  m_axis_tvalid/tready      sector, switches, torque
//   cfg       in   cfg_we_i (no backpressure) cfg_idx_i, cfg_data_i
//
// A request is taken every cycle unless a finished result is held; the result
// passes the input register, speed loop stage, current scaling stage and
// output register in that order. The speed loop state closes within one stage.
// Reset restores the register defaults and clears the loop and carrier
// state. A stalled result freezes the whole pipeline and drops s_axis_tready.
// ----------------------------------------------------------------------------
module bldc_six_step_speed_controller_unit #(
  parameter int unsigned DATA_WIDTH = bssc_pkg::DataWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Control tick requests
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // measured_speed[15:0], rotor_angle[27:16], current_a[43:28],
  // current_b[59:44], current_c[75:60], zero[79:76]
  input  logic [79:0]                   s_axis_tdata,
  // Results
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // sector[2:0], switch_a[4:3], switch_b[6:5], switch_c[8:7],
  // torque_command[24:9], zero[31:25]
  output logic [31:0]                   m_axis_tdata,
  // Configuration writes
  input  logic                          cfg_we_i,
  input  logic [bssc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bssc_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam logic signed [33:0] DMax = (34'sd1 <<< (DATA_WIDTH - 1)) - 34'sd1;
  localparam logic signed [33:0] DMin = -(34'sd1 <<< (DATA_WIDTH - 1));

  localparam logic [11:0] AngFull = 12'(bssc_pkg::AngleFull);
  localparam logic [11:0] Bound0  = 12'(bssc_pkg::SecBound0);
  localparam logic [11:0] Bound1  = 12'(bssc_pkg::SecBound1);
  localparam logic [11:0] Bound2  = 12'(bssc_pkg::SecBound2);
  localparam logic [11:0] Bound3  = 12'(bssc_pkg::SecBound3);
  localparam logic [11:0] Bound4  = 12'(bssc_pkg::SecBound4);
  localparam logic [11:0] Bound5  = 12'(bssc_pkg::SecBound5);

  bssc_pkg::cfg_t       cfg_q;
  bssc_pkg::stage_ctl_t ctl;
  logic                 adv;

  // Input register
  logic                 v0_q;
  logic signed [15:0]   speed0_q;
  logic [11:0]          angle0_q;
  logic signed [15:0]   ia0_q, ib0_q, ic0_q;

  // Speed loop stage
  logic                 v1_q;
  logic signed [15:0]   tcmd1_q;
  logic signed [bssc_pkg::TriW-1:0] tri1_q;
  bssc_pkg::sector_e    sector1_q;
  logic signed [15:0]   ia1_q, ib1_q, ic1_q;

  // Current scaling stage
  logic                 v2_q;
  logic signed [DATA_WIDTH-1:0] ip2_q;
  logic signed [15:0]   tcmd2_q;
  logic signed [bssc_pkg::TriW-1:0] tri2_q;
  bssc_pkg::sector_e    sector2_q;
  logic signed [15:0]   ia2_q, ib2_q, ic2_q;

  // Output register
  logic                 vo_q;
  bssc_pkg::sector_e    sector_q;
  bssc_pkg::switch_e    sw_a_q, sw_b_q, sw_c_q;
  logic signed [15:0]   tcmd_q;

  logic signed [15:0]   tcmd_d;
  logic signed [bssc_pkg::TriW-1:0] tri_d;
  bssc_pkg::sector_e    sector_d;
  logic [11:0]          ang;
  logic signed [32:0]   ip_prod;
  logic signed [33:0]   ip_wide;
  logic signed [DATA_WIDTH-1:0] ip_d;
  bssc_pkg::switch_e    sw_a_d, sw_b_d, sw_c_d;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= bssc_pkg::CfgRst;
    end else if (cfg_we_i) begin
      unique case (bssc_pkg::cfg_idx_e'(cfg_idx_i))
        bssc_pkg::CFG_SPEED_CMD:     cfg_q.speed_command     <= cfg_data_i[15:0];
        bssc_pkg::CFG_SPEED_KP:      cfg_q.speed_prop_gain   <= cfg_data_i[15:0];
        bssc_pkg::CFG_SPEED_KI:      cfg_q.speed_int_gain    <= cfg_data_i[23:0];
        bssc_pkg::CFG_TORQUE_LIM:    cfg_q.torque_limit      <= cfg_data_i[14:0];
        bssc_pkg::CFG_TORQUE_TO_CUR: cfg_q.torque_to_current <= cfg_data_i[15:0];
        bssc_pkg::CFG_CUR_GAIN:      cfg_q.current_gain      <= cfg_data_i[9:0];
        bssc_pkg::CFG_VOLT_LIM:      cfg_q.voltage_limit     <= cfg_data_i[14:0];
        bssc_pkg::CFG_CARRIER_STEP:  cfg_q.carrier_step      <= cfg_data_i[13:0];
        default: ;
      endcase
    end
  end

  // Whole pipeline moves unless a finished result is held
  assign adv           = !vo_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign ctl.adv       = adv;
  assign ctl.vld       = v0_q;

  // Speed loop and carrier, state advanced per request
  bssc_speed_loop u_speed_loop (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctl_i            (ctl),
    .cfg_i            (cfg_q),
    .measured_speed_i (speed0_q),
    .torque_command_o (tcmd_d)
  );

  bssc_carrier u_carrier (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .carrier_step_i (cfg_q.carrier_step),
    .tri_o          (tri_d)
  );

  // Wrap the angle and pick the 60-degree sector
  always_comb begin
    ang = (angle0_q >= AngFull) ? (angle0_q - AngFull) : angle0_q;
    if (ang < Bound0 || ang >= Bound5) begin
      sector_d = bssc_pkg::SEC0;
    end else if (ang < Bound1) begin
      sector_d = bssc_pkg::SEC1;
    end else if (ang < Bound2) begin
      sector_d = bssc_pkg::SEC2;
    end else if (ang < Bound3) begin
      sector_d = bssc_pkg::SEC3;
    end else if (ang < Bound4) begin
      sector_d = bssc_pkg::SEC4;
    end else begin
      sector_d = bssc_pkg::SEC5;
    end
  end

  // Torque to current command, floored and saturated
  assign ip_prod = tcmd1_q * $signed({1'b0, cfg_q.torque_to_current});
  assign ip_wide = {{9{ip_prod[32]}}, ip_prod[32:8]};

  always_comb begin
    if (ip_wide > DMax) begin
      ip_d = DMax[DATA_WIDTH-1:0];
    end else if (ip_wide < DMin) begin
      ip_d = DMin[DATA_WIDTH-1:0];
    end else begin
      ip_d = ip_wide[DATA_WIDTH-1:0];
    end
  end

  // Commutation and phase current loops
  bssc_phase_ctrl #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_phase_ctrl (
    .cur_cmd_i   (ip2_q),
    .sector_i    (sector2_q),
    .current_a_i (ia2_q),
    .current_b_i (ib2_q),
    .current_c_i (ic2_q),
    .tri_i       (tri2_q),
    .cfg_i       (cfg_q),
    .switch_a_o  (sw_a_d),
    .switch_b_o  (sw_b_d),
    .switch_c_o  (sw_c_d)
  );

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (adv) begin
      v0_q <= s_axis_tvalid;
      v1_q <= v0_q;
      v2_q <= v1_q;
      vo_q <= v2_q;
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (adv) begin
      speed0_q  <= s_axis_tdata[15:0];
      angle0_q  <= s_axis_tdata[27:16];
      ia0_q     <= s_axis_tdata[43:28];
      ib0_q     <= s_axis_tdata[59:44];
      ic0_q     <= s_axis_tdata[75:60];

      tcmd1_q   <= tcmd_d;
      tri1_q    <= tri_d;
      sector1_q <= sector_d;
      ia1_q     <= ia0_q;
      ib1_q     <= ib0_q;
      ic1_q     <= ic0_q;

      ip2_q     <= ip_d;
      tcmd2_q   <= tcmd1_q;
      tri2_q    <= tri1_q;
      sector2_q <= sector1_q;
      ia2_q     <= ia1_q;
      ib2_q     <= ib1_q;
      ic2_q     <= ic1_q;

      sector_q  <= sector2_q;
      sw_a_q    <= sw_a_d;
      sw_b_q    <= sw_b_d;
      sw_c_q    <= sw_c_d;
      tcmd_q    <= tcmd2_q;
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = {7'b0, tcmd_q, sw_c_q, sw_b_q, sw_a_q, sector_q};

`ifndef SYNTHESIS
  // Delivered torque stays inside the configured clamp
  a_torque_clamped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[24:9]) <= $signed({1'b0, cfg_q.torque_limit}))
                   && ($signed(m_axis_tdata[24:9]) >= -$signed({1'b0, cfg_q.torque_limit})))
    else $error("torque command outside the clamp");

  // Exactly one phase floats in every result
  a_one_float : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $countones({sw_a_q == bssc_pkg::SW_FLOAT,
                                  sw_b_q == bssc_pkg::SW_FLOAT,
                                  sw_c_q == bssc_pkg::SW_FLOAT}) == 1)
    else $error("floating phase count is not one");

  // No empty output slot ever blocks the input side
  a_ready_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with no result waiting");

  // An accepted request reaches the output register when every stage advances
  // after the accepting edge
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && m_axis_tready) ##1 m_axis_tready
      ##1 m_axis_tready ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("accepted request lost in the pipeline");
`endif

endmodule

// ===== design/bssc_speed_loop.sv =====
// ----------------------------------------------------------------------------
// bssc_speed_loop: PI speed loop with back-calculation anti-windup
// Holds the 48-bit integrator and the clamp excess of the previous tick and
// produces the clamped torque command of the request in the input register.
// ----------------------------------------------------------------------------
module bssc_speed_loop (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  bssc_pkg::stage_ctl_t     ctl_i,
  input  bssc_pkg::cfg_t           cfg_i,
  input  logic signed [15:0]       measured_speed_i,
  output logic signed [15:0]       torque_command_o
);

  localparam logic signed [47:0] IntegMax = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] IntegMin = {1'b1, {47{1'b0}}};
  localparam logic signed [27:0] ExcessMax = 28'sd65535;
  localparam logic signed [27:0] ExcessMin = -28'sd65536;

  logic signed [47:0] integ_q, integ_d;
  logic signed [16:0] excess_q, excess_d;
  logic signed [16:0] err;
  logic signed [21:0] inc;
  logic signed [46:0] inc_prod;
  logic signed [48:0] integ_sum;
  logic signed [33:0] prop_prod;
  logic signed [26:0] star;
  logic signed [26:0] lim;
  logic signed [26:0] lim_neg;
  logic signed [26:0] tcmd;
  logic signed [27:0] excess_full;

  // Speed error in Q.4
  assign err = {cfg_i.speed_command[15], cfg_i.speed_command}
             - {measured_speed_i[15], measured_speed_i};

  // Integrator step: (err*16 + excess) * Ki, saturated to 48 bits
  assign inc       = {err[16], err, 4'b0} + {{5{excess_q[16]}}, excess_q};
  assign inc_prod  = inc * $signed({1'b0, cfg_i.speed_int_gain});
  assign integ_sum = {integ_q[47], integ_q} + {{2{inc_prod[46]}}, inc_prod};

  always_comb begin
    if (integ_sum[48] != integ_sum[47]) begin
      integ_d = integ_sum[48] ? IntegMin : IntegMax;
    end else begin
      integ_d = integ_sum[47:0];
    end
  end

  // Unclamped torque: floored integrator plus floored proportional term
  assign prop_prod = err * $signed({1'b0, cfg_i.speed_prop_gain});
  assign star      = {{11{integ_d[47]}}, integ_d[47:32]}
                   + {prop_prod[33], prop_prod[33:8]};

  // Clamp to the symmetric torque limit
  assign lim     = {12'b0, cfg_i.torque_limit};
  assign lim_neg = -lim;

  always_comb begin
    if (star >= lim) begin
      tcmd = lim;
    end else if (star <= lim_neg) begin
      tcmd = lim_neg;
    end else begin
      tcmd = star;
    end
  end

  // Excess fed back to the integrator on the next tick
  assign excess_full = {tcmd[26], tcmd} - {star[26], star};

  always_comb begin
    if (excess_full > ExcessMax) begin
      excess_d = ExcessMax[16:0];
    end else if (excess_full < ExcessMin) begin
      excess_d = ExcessMin[16:0];
    end else begin
      excess_d = excess_full[16:0];
    end
  end

  assign torque_command_o = tcmd[15:0];

  // Commit the loop state once per accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q  <= '0;
      excess_q <= '0;
    end else if (ctl_i.adv && ctl_i.vld) begin
      integ_q  <= integ_d;
      excess_q <= excess_d;
    end
  end

endmodule

// ===== design/bssc_carrier.sv =====
// ----------------------------------------------------------------------------
// bssc_carrier: triangle carrier for the phase comparators
// Gives the carrier value of the current tick and advances the phase by the
// configured step once per request, folding it back by one period.
// ----------------------------------------------------------------------------
module bssc_carrier (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bssc_pkg::stage_ctl_t                ctl_i,
  input  logic [13:0]                         carrier_step_i,
  output logic signed [bssc_pkg::TriW-1:0]    tri_o
);

  localparam int unsigned PW = bssc_pkg::CarrierW;

  localparam logic [PW-1:0]      Peak      = PW'(bssc_pkg::CarrierPeak);
  localparam logic [PW-1:0]      Peak3     = PW'(3 * bssc_pkg::CarrierPeak);
  localparam logic signed [PW:0] Peak2S    = (PW+1)'(2 * bssc_pkg::CarrierPeak);
  localparam logic signed [PW:0] PeriodS   = (PW+1)'(bssc_pkg::CarrierPeriod);
  localparam logic [PW:0]        PeriodU   = (PW+1)'(bssc_pkg::CarrierPeriod);
  localparam logic signed [PW:0] TriMaxS   = (PW+1)'((1 << (bssc_pkg::TriW - 1)) - 1);

  // The phase register is wider than one period so that a step above the
  // period is still tracked exactly
  logic [PW-1:0]      phase_q, phase_d;
  logic signed [PW:0] p_s;
  logic signed [PW:0] tri_w;
  logic [PW:0]        sum;

  assign p_s = {1'b0, phase_q};

  // Fold the phase into the triangle
  always_comb begin
    if (phase_q < Peak) begin
      tri_w = p_s;
    end else if (phase_q < Peak3) begin
      tri_w = Peak2S - p_s;
    end else begin
      tri_w = p_s - PeriodS;
    end
  end

  // Values above the largest voltage demand compare the same when capped
  assign tri_o = (tri_w > TriMaxS) ? TriMaxS[bssc_pkg::TriW-1:0]
                                   : tri_w[bssc_pkg::TriW-1:0];

  // Advance the phase, subtract one period on wrap
  always_comb begin
    sum = {1'b0, phase_q} + (PW+1)'(carrier_step_i);
    if (sum >= PeriodU) begin
      sum = sum - PeriodU;
    end
    phase_d = sum[PW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (ctl_i.adv && ctl_i.vld) begin
      phase_q <= phase_d;
    end
  end

endmodule

// ===== design/bssc_phase_ctrl.sv =====
// ----------------------------------------------------------------------------
// bssc_phase_ctrl: commutation and per-phase current loops
// Maps the sector to the current targets of the two conducting phases, runs
// the clamped proportional current loop on each and compares with the carrier.
// ----------------------------------------------------------------------------
module bssc_phase_ctrl #(
  parameter int unsigned DATA_WIDTH = bssc_pkg::DataWidthDef
) (
  input  logic signed [DATA_WIDTH-1:0]        cur_cmd_i,
  input  bssc_pkg::sector_e                   sector_i,
  input  logic signed [15:0]                  current_a_i,
  input  logic signed [15:0]                  current_b_i,
  input  logic signed [15:0]                  current_c_i,
  input  logic signed [bssc_pkg::TriW-1:0]    tri_i,
  input  bssc_pkg::cfg_t                      cfg_i,
  output bssc_pkg::switch_e                   switch_a_o,
  output bssc_pkg::switch_e                   switch_b_o,
  output bssc_pkg::switch_e                   switch_c_o
);

  localparam int unsigned DiffW = ((DATA_WIDTH > 16) ? DATA_WIDTH : 16) + 2;
  localparam int unsigned VW    = DiffW + 11;

  // Proportional current loop of one phase, clamped, against the carrier
  function automatic bssc_pkg::switch_e drive(
    input logic signed [DiffW-1:0]          tgt,
    input logic signed [15:0]               meas,
    input logic [9:0]                       gain,
    input logic [14:0]                      vlim,
    input logic signed [bssc_pkg::TriW-1:0] tri_v
  );
    logic signed [DiffW-1:0] diff;
    logic signed [VW-1:0]    v;
    logic signed [VW-1:0]    vl;
    logic signed [VW-1:0]    vcl;
    diff = tgt - DiffW'(meas);
    v    = diff * $signed({1'b0, gain});
    vl   = VW'($signed({1'b0, vlim}));
    if (v > vl) begin
      vcl = vl;
    end else if (v < -vl) begin
      vcl = -vl;
    end else begin
      vcl = v;
    end
    return (vcl >= VW'(tri_v)) ? bssc_pkg::SW_HIGH : bssc_pkg::SW_LOW;
  endfunction

  logic signed [DiffW-1:0] ip_pos;
  logic signed [DiffW-1:0] ip_neg;

  assign ip_pos = DiffW'(cur_cmd_i);
  assign ip_neg = -ip_pos;

  // One phase floats, one takes +I and one takes -I
  always_comb begin
    unique case (sector_i)
      bssc_pkg::SEC0: begin
        switch_a_o = bssc_pkg::SW_FLOAT;
        switch_b_o = drive(ip_neg, current_b_i, cfg_i.current_gain,
                           cfg_i.voltage_limit, tri_i);
        switch_c_o = drive(ip_pos, current_c_i, cfg_i.current_gain,
                           cfg_i.voltage_limit, tri_i);
      end
      bssc_pkg::SEC1: begin
        switch_a_o = drive(ip_pos, current_a_i, cfg_i.current_gain,
                           cfg_i.voltage_limit, tri_i);
        switch_b_o = drive(ip_neg, current_b_i, cfg_i.current_gain,
                           cfg_i.voltage_limit, tri_i);
        switch_c_o = bssc_pkg::SW_FLOAT;
      end
      bssc_pkg::SEC2: begin
        switch_a_o = drive(ip_pos, current_a_i, cfg_i.current_gain,
                           cfg_i.voltage_limit, tri_i);
        switch_b_o = bssc_pkg::SW_FLOAT;
        switch_c_o = drive(ip_neg, current_c_i, cfg_i.current_gain,
                           cfg_i.voltage_limit, tri_i);
      end
      bssc_pkg::SEC3: begin
        switch_a_o = bssc_pkg::SW_FLOAT;
        switch_b_o = drive(ip_pos, current_b_i, cfg_i.current_gain,
                           cfg_i.voltage_limit, tri_i);
        switch_c_o = drive(ip_neg, current_c_i, cfg_i.current_gain,
                           cfg_i.voltage_limit, tri_i);
      end
      bssc_pkg::SEC4: begin
        switch_a_o = drive(ip_neg, current_a_i, cfg_i.current_gain,
                           cfg_i.voltage_limit, tri_i);
        switch_b_o = drive(ip_pos, current_b_i, cfg_i.current_gain,
                           cfg_i.voltage_limit, tri_i);
        switch_c_o = bssc_pkg::SW_FLOAT;
      end
      default: begin
        switch_a_o = drive(ip_neg, current_a_i, cfg_i.current_gain,
                           cfg_i.voltage_limit, tri_i);
        switch_b_o = bssc_pkg::SW_FLOAT;
        switch_c_o = drive(ip_pos, current_c_i, cfg_i.current_gain,
                           cfg_i.voltage_limit, tri_i);
      end
    endcase
  end

endmodule
